// ===== rtl/core/tfsc_pkg.sv =====
`default_nettype none
package tfsc_pkg;

  localparam int unsigned TEMP_W = 11;
  localparam int unsigned SPD_W  = 4;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned NFANS  = 3;

  localparam logic [SPD_W-1:0] TOP_SPEED_MAX    = SPD_W'(5);
  localparam logic [SPD_W-1:0] TOP_SPEED_MIN    = SPD_W'(1);
  localparam logic [SPD_W-1:0] SIDE_SPEED_MAX   = SPD_W'(10);
  localparam logic [SPD_W-1:0] SIDE_SPEED_MIN   = SPD_W'(1);
  localparam logic [SPD_W-1:0] AUTO_START_SPEED = SPD_W'(2);
  localparam logic [CNT_W-1:0] HOLD_TICKS       = CNT_W'(16);

  // Fan lane order.
  localparam int unsigned LANE_TOP   = 0;
  localparam int unsigned LANE_LEFT  = 1;
  localparam int unsigned LANE_RIGHT = 2;

  typedef enum logic [2:0] {
    CFG_AUTO_ENABLE  = 3'd0,
    CFG_MANUAL_TOP   = 3'd1,
    CFG_MANUAL_SIDE  = 3'd2,
    CFG_TEMP_HIGH    = 3'd3,
    CFG_TEMP_LOW     = 3'd4,
    CFG_SIDE_RISK    = 3'd5,
    CFG_TOP_RISK     = 3'd6,
    CFG_TOP_NORMAL   = 3'd7
  } cfg_idx_e;

  // Per-lane limits and thresholds.
  typedef struct packed {
    logic signed [TEMP_W-1:0] risk;
    logic signed [TEMP_W-1:0] release_lvl;
    logic signed [TEMP_W-1:0] high_th;
    logic signed [TEMP_W-1:0] low_th;
    logic [SPD_W-1:0]         manual_spd;
    logic [SPD_W-1:0]         spd_max;
    logic [SPD_W-1:0]         spd_min;
  } lane_cfg_t;

  // Control from the merging stage back to every lane.
  typedef struct packed {
    logic rescuing;
    logic auto_en;
    logic entering;
  } lane_ctrl_t;

  // What a lane found in this tick.
  typedef struct packed {
    logic             over_risk;
    logic             rescue;
    logic [SPD_W-1:0] applied;
  } lane_stat_t;

  typedef struct packed {
    logic [SPD_W-1:0] top_spd;
    logic [SPD_W-1:0] left_spd;
    logic [SPD_W-1:0] right_spd;
    logic             rescuing;
    logic             overheat;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/tfsc_lane.sv =====
`default_nettype none
module tfsc_lane (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   accept_i,
  input  wire logic signed [tfsc_pkg::TEMP_W-1:0]     temp_i,
  input  wire tfsc_pkg::lane_cfg_t                    cfg_i,
  input  wire tfsc_pkg::lane_ctrl_t                   ctrl_i,
  output tfsc_pkg::lane_stat_t                        stat_o
);

  logic [tfsc_pkg::SPD_W-1:0] auto_spd_q, auto_spd_d;
  logic                       hold_q, hold_d;
  logic [tfsc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       rescue_q, rescue_d;
  logic [tfsc_pkg::SPD_W-1:0] saved_q, saved_d;
  logic [tfsc_pkg::SPD_W-1:0] applied_q, applied_d;

  logic                       over_risk;
  logic [tfsc_pkg::SPD_W-1:0] rescue_spd;
  logic [tfsc_pkg::SPD_W-1:0] spd_base;
  logic                       hold_base;
  logic [tfsc_pkg::CNT_W-1:0] cnt_base;
  logic [tfsc_pkg::CNT_W-1:0] cnt_inc;
  logic [tfsc_pkg::SPD_W-1:0] manual_clamped;

  assign over_risk = temp_i > cfg_i.risk;
  assign cnt_inc   = cnt_q + tfsc_pkg::CNT_W'(1);

  always_comb begin
    if (cfg_i.manual_spd < cfg_i.spd_min) begin
      manual_clamped = cfg_i.spd_min;
    end else if (cfg_i.manual_spd > cfg_i.spd_max) begin
      manual_clamped = cfg_i.spd_max;
    end else begin
      manual_clamped = cfg_i.manual_spd;
    end
  end

  // Rescue is evaluated first; its outcome feeds the global rescue flag.
  always_comb begin
    rescue_d   = rescue_q;
    saved_d    = saved_q;
    rescue_spd = applied_q;
    if (over_risk) begin
      if (!rescue_q) begin
        saved_d    = applied_q;
        rescue_d   = 1'b1;
        rescue_spd = cfg_i.spd_max;
      end
    end else if (rescue_q && (temp_i < cfg_i.release_lvl)) begin
      rescue_spd = saved_q;
      rescue_d   = 1'b0;
    end
  end

  always_comb begin
    auto_spd_d = auto_spd_q;
    hold_d     = hold_q;
    cnt_d      = cnt_q;
    applied_d  = rescue_spd;
    spd_base   = auto_spd_q;
    hold_base  = hold_q;
    cnt_base   = cnt_q;
    if (!ctrl_i.rescuing) begin
      if (ctrl_i.auto_en) begin
        if (ctrl_i.entering) begin
          spd_base  = tfsc_pkg::AUTO_START_SPEED;
          hold_base = 1'b0;
          cnt_base  = '0;
          applied_d = tfsc_pkg::AUTO_START_SPEED;
        end
        auto_spd_d = spd_base;
        hold_d     = hold_base;
        cnt_d      = cnt_base;
        if (hold_base) begin
          // A fan entering auto never holds, so the stored count is the right one here.
          if (cnt_inc == tfsc_pkg::HOLD_TICKS) begin
            hold_d = 1'b0;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end else if (temp_i > cfg_i.high_th) begin
          if (spd_base < cfg_i.spd_max) begin
            auto_spd_d = spd_base + tfsc_pkg::SPD_W'(1);
            applied_d  = spd_base + tfsc_pkg::SPD_W'(1);
            hold_d     = 1'b1;
            cnt_d      = '0;
          end
        end else if (temp_i < cfg_i.low_th) begin
          if (spd_base > cfg_i.spd_min) begin
            auto_spd_d = spd_base - tfsc_pkg::SPD_W'(1);
            applied_d  = spd_base - tfsc_pkg::SPD_W'(1);
            hold_d     = 1'b1;
            cnt_d      = '0;
          end
        end
      end else begin
        applied_d = manual_clamped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_spd_q <= tfsc_pkg::AUTO_START_SPEED;
      hold_q     <= 1'b0;
      cnt_q      <= '0;
      rescue_q   <= 1'b0;
      applied_q  <= '0;
    end else if (accept_i) begin
      auto_spd_q <= auto_spd_d;
      hold_q     <= hold_d;
      cnt_q      <= cnt_d;
      rescue_q   <= rescue_d;
      applied_q  <= applied_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      saved_q <= saved_d;
    end
  end

  assign stat_o.over_risk = over_risk;
  assign stat_o.rescue    = rescue_d;
  assign stat_o.applied   = applied_d;

endmodule
`default_nettype wire

// ===== rtl/core/tfsc_merge.sv =====
`default_nettype none
module tfsc_merge (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic                      auto_en_i,
  input  wire tfsc_pkg::lane_stat_t      top_stat_i,
  input  wire tfsc_pkg::lane_stat_t      left_stat_i,
  input  wire tfsc_pkg::lane_stat_t      right_stat_i,
  output tfsc_pkg::lane_ctrl_t           ctrl_o,
  output logic                           full_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output tfsc_pkg::result_t              result_o
);

  logic             prev_auto_q;
  logic             rescuing;
  tfsc_pkg::result_t res;

  tfsc_pkg::result_t buf_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign rescuing = top_stat_i.rescue | left_stat_i.rescue | right_stat_i.rescue;

  assign ctrl_o.rescuing = rescuing;
  assign ctrl_o.auto_en  = auto_en_i;
  assign ctrl_o.entering = !prev_auto_q && auto_en_i;

  assign res.top_spd   = top_stat_i.applied;
  assign res.left_spd  = left_stat_i.applied;
  assign res.right_spd = right_stat_i.applied;
  assign res.rescuing  = rescuing;
  assign res.overheat  = top_stat_i.over_risk & left_stat_i.over_risk &
                         right_stat_i.over_risk;

  // A mode change seen during rescue only counts once rescue is over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_auto_q <= 1'b0;
    end else if (accept_i && !rescuing) begin
      prev_auto_q <= auto_en_i;
    end
  end

  // Two-entry result queue keeps the input side moving while a result waits.
  assign out_valid_o = cnt_q != 2'd0;
  assign full_o      = cnt_q == 2'd2;
  assign pop         = out_valid_o && !out_stall_i;
  assign result_o    = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (accept_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!accept_i && pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/thermal_fan_speed_controller.sv =====
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   temp_top_i, temp_left_i, temp_right_i
// out      output     out_valid_o / out_stall_i top/left/right_fan_speed_o, rescuing_o,
//                                               overheat_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each request is handled by three fan lanes side by side; a new request can be taken
// every cycle while the queue is not full, and its result is written into the queue.
// Results sit in a two-entry queue, so the input stalls only while two results wait.
// Reset loads control and config reset values, but not saved speeds or queue data.
// The configuration port is always ready.
module thermal_fan_speed_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [tfsc_pkg::TEMP_W-1:0] temp_top_i,
  input  wire logic signed [tfsc_pkg::TEMP_W-1:0] temp_left_i,
  input  wire logic signed [tfsc_pkg::TEMP_W-1:0] temp_right_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [tfsc_pkg::SPD_W-1:0]              top_fan_speed_o,
  output logic [tfsc_pkg::SPD_W-1:0]              left_fan_speed_o,
  output logic [tfsc_pkg::SPD_W-1:0]              right_fan_speed_o,
  output logic                                    rescuing_o,
  output logic                                    overheat_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [2:0]                         cfg_index_i,
  input  wire logic [tfsc_pkg::TEMP_W-1:0]        cfg_data_i
);

  logic                               auto_en_q;
  logic [tfsc_pkg::SPD_W-1:0]         man_top_q;
  logic [tfsc_pkg::SPD_W-1:0]         man_side_q;
  logic signed [tfsc_pkg::TEMP_W-1:0] high_th_q;
  logic signed [tfsc_pkg::TEMP_W-1:0] low_th_q;
  logic signed [tfsc_pkg::TEMP_W-1:0] side_risk_q;
  logic signed [tfsc_pkg::TEMP_W-1:0] top_risk_q;
  logic signed [tfsc_pkg::TEMP_W-1:0] top_normal_q;

  logic                  accept;
  logic                  full;
  tfsc_pkg::lane_ctrl_t  ctrl;
  tfsc_pkg::lane_cfg_t   top_cfg, left_cfg, right_cfg;
  tfsc_pkg::lane_stat_t  top_stat, left_stat, right_stat;
  tfsc_pkg::result_t     result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en_q    <= 1'b0;
      man_top_q    <= tfsc_pkg::SPD_W'(2);
      man_side_q   <= tfsc_pkg::SPD_W'(2);
      high_th_q    <= tfsc_pkg::TEMP_W'(45);
      low_th_q     <= tfsc_pkg::TEMP_W'(35);
      side_risk_q  <= tfsc_pkg::TEMP_W'(70);
      top_risk_q   <= tfsc_pkg::TEMP_W'(70);
      top_normal_q <= tfsc_pkg::TEMP_W'(50);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tfsc_pkg::cfg_idx_e'(cfg_index_i))
        tfsc_pkg::CFG_AUTO_ENABLE: auto_en_q    <= cfg_data_i[0];
        tfsc_pkg::CFG_MANUAL_TOP:  man_top_q    <= cfg_data_i[tfsc_pkg::SPD_W-1:0];
        tfsc_pkg::CFG_MANUAL_SIDE: man_side_q   <= cfg_data_i[tfsc_pkg::SPD_W-1:0];
        tfsc_pkg::CFG_TEMP_HIGH:   high_th_q    <= cfg_data_i;
        tfsc_pkg::CFG_TEMP_LOW:    low_th_q     <= cfg_data_i;
        tfsc_pkg::CFG_SIDE_RISK:   side_risk_q  <= cfg_data_i;
        tfsc_pkg::CFG_TOP_RISK:    top_risk_q   <= cfg_data_i;
        tfsc_pkg::CFG_TOP_NORMAL:  top_normal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  assign top_cfg.risk        = top_risk_q;
  assign top_cfg.release_lvl = top_normal_q;
  assign top_cfg.high_th     = high_th_q;
  assign top_cfg.low_th      = low_th_q;
  assign top_cfg.manual_spd  = man_top_q;
  assign top_cfg.spd_max     = tfsc_pkg::TOP_SPEED_MAX;
  assign top_cfg.spd_min     = tfsc_pkg::TOP_SPEED_MIN;

  assign left_cfg.risk        = side_risk_q;
  assign left_cfg.release_lvl = low_th_q;
  assign left_cfg.high_th     = high_th_q;
  assign left_cfg.low_th      = low_th_q;
  assign left_cfg.manual_spd  = man_side_q;
  assign left_cfg.spd_max     = tfsc_pkg::SIDE_SPEED_MAX;
  assign left_cfg.spd_min     = tfsc_pkg::SIDE_SPEED_MIN;

  assign right_cfg = left_cfg;

  tfsc_lane u_lane_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .temp_i   (temp_top_i),
    .cfg_i    (top_cfg),
    .ctrl_i   (ctrl),
    .stat_o   (top_stat)
  );

  tfsc_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .temp_i   (temp_left_i),
    .cfg_i    (left_cfg),
    .ctrl_i   (ctrl),
    .stat_o   (left_stat)
  );

  tfsc_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .temp_i   (temp_right_i),
    .cfg_i    (right_cfg),
    .ctrl_i   (ctrl),
    .stat_o   (right_stat)
  );

  tfsc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .auto_en_i    (auto_en_q),
    .top_stat_i   (top_stat),
    .left_stat_i  (left_stat),
    .right_stat_i (right_stat),
    .ctrl_o       (ctrl),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign top_fan_speed_o   = result.top_spd;
  assign left_fan_speed_o  = result.left_spd;
  assign right_fan_speed_o = result.right_spd;
  assign rescuing_o        = result.rescuing;
  assign overheat_o        = result.overheat;

endmodule
`default_nettype wire
